### hw/rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// Transaction structs, command and status codes, controller/datapath links.
// No dependencies.
package dq_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;
  localparam logic [2:0] CMD_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 7;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic [OCC_W-1:0]         occupancy;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       ram_we;
    logic       ram_re;
    logic       sel_front;
    logic       move;
    logic       clear;
    logic       respond;
    logic       read_ok;
    logic [1:0] status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       full;
  } dp_stat_t;

endpackage

### hw/rtl/dq_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/dq_ctrl.sv
// Controller FSM for the double-ended queue: accepts transactions, decodes the
// command against empty/full, and sequences execute and respond steps.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output ctl_t     ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] status_code, status_code_next;
  logic       read_ok, read_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      status_code <= ST_OK;
      read_ok     <= 1'b0;
    end else begin
      state       <= state_next;
      status_code <= status_code_next;
      read_ok     <= read_ok_next;
    end
  end

  always_comb begin
    ctl              = '0;
    state_next       = state;
    status_code_next = status_code;
    read_ok_next     = read_ok;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        status_code_next = ST_OK;
        read_ok_next     = 1'b0;
        case (stat.cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (stat.full) begin
              status_code_next = ST_FULL;
            end else begin
              ctl.ram_we    = 1'b1;
              ctl.move      = 1'b1;
              ctl.sel_front = (stat.cmd == CMD_PUSH_FRONT);
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
            if (stat.empty) begin
              status_code_next = ST_EMPTY;
            end else begin
              ctl.ram_re    = 1'b1;
              read_ok_next  = 1'b1;
              ctl.move      = (stat.cmd == CMD_POP_FRONT) || (stat.cmd == CMD_POP_BACK);
              ctl.sel_front = (stat.cmd == CMD_POP_FRONT) || (stat.cmd == CMD_PEEK_FRONT);
            end
          end
          CMD_CLEAR: begin
            ctl.clear = 1'b1;
          end
          default: begin
          end
        endcase
        state_next = S_RESP;
      end
      S_RESP: begin
        ctl.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    ctl.status  = status_code;
    ctl.read_ok = read_ok;
  end

  assign busy = (state != S_IDLE);

endmodule

### hw/rtl/dq_datapath.sv
// Datapath for the double-ended queue: transaction register, front/back
// pointers, occupancy count, entry RAM and result register.
// Depends on dq_pkg and dq_ram.
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  in_t      request,
  input  ctl_t     ctl,
  output dp_stat_t stat,
  output logic     done,
  output out_t     result
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  in_t              item;
  logic [PW-1:0]    front_ptr, back_ptr;
  logic [CW-1:0]    count;
  logic [PW-1:0]    addr;
  logic [DATA_W-1:0] rdata;

  always_comb begin
    if (ctl.sel_front) begin
      addr = ctl.ram_we ? ptr_dec(front_ptr) : front_ptr;
    end else begin
      addr = ctl.ram_we ? back_ptr : ptr_dec(back_ptr);
    end
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (addr),
    .wdata (item.data_in),
    .re    (ctl.ram_re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= request;
    end
    if (ctl.respond) begin
      result.status    <= ctl.status;
      result.data_out  <= ctl.read_ok ? $signed(rdata) : '0;
      result.occupancy <= OCC_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      back_ptr  <= '0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      done <= ctl.respond;
      if (ctl.clear) begin
        front_ptr <= '0;
        back_ptr  <= '0;
        count     <= '0;
      end else if (ctl.move) begin
        if (ctl.sel_front) begin
          front_ptr <= ctl.ram_we ? ptr_dec(front_ptr) : ptr_inc(front_ptr);
        end else begin
          back_ptr <= ctl.ram_we ? ptr_inc(back_ptr) : ptr_dec(back_ptr);
        end
        count <= ctl.ram_we ? count + 1'b1 : count - 1'b1;
      end
    end
  end

  assign stat.cmd   = item.cmd;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_FULL);

endmodule

### hw/rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values.
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. request carries the command (push/pop/peek at either end,
//   clear) and the value to push.
//   Result channel: done is high for exactly one cycle with result holding
//   status (ok, empty, full), the popped or peeked value (zero otherwise)
//   and the occupancy after the command. The receiver cannot stall it.
// Timing:
//   After acceptance the controller decodes the command and accesses the
//   entry RAM (registered read), then the result register is loaded. busy
//   stays high until the result is loaded, so a new transaction is not
//   taken while one is in flight; the next may be accepted in the same
//   cycle the previous result is shown.
// Reset:
//   Synchronous rst empties the queue (pointers and count to zero) and
//   drops busy and done. The entry RAM is not cleared; only occupied
//   entries are ever read.
// Depends on dq_pkg, dq_ctrl, dq_datapath, dq_ram.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic done,
  output out_t result
);

  ctl_t     ctl;
  dp_stat_t stat;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

### hw/rtl/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue.
module dq_checker
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input out_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("transaction accepted but block not busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> (result.data_out == '0))
    else $error("refused transaction returned data");

  a_occupancy_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.occupancy) <= DEPTH) && (result.status != 2'd3))
    else $error("result status or occupancy out of range");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### verif/double_ended_queue_tb.sv
// Self-checking testbench for double_ended_queue: directed corner cases, then
// biased random fill/drain/mixed command streams under varying sender gaps.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 100ps

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int unsigned QDEPTH = 64;
  localparam int PW = $clog2(QDEPTH);
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 730;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_e;

  typedef struct {
    in_t         req;
    int unsigned gap;
    bit          drain;
  } pending_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  request = '0;
  logic done;
  out_t result;

  pending_cmd_t cmd_backlog[$];
  out_t         expected_results[$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  bit           head_ready = 1'b0;
  int unsigned  gap_left = 0;

  // shadow deque
  logic signed [DATA_W-1:0] shadow_store[QDEPTH];
  logic [PW-1:0]            shadow_front = '0;
  logic [PW-1:0]            shadow_back = '0;
  logic [OCC_W-1:0]         shadow_count = '0;

  double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always #2 clk = ~clk;

  function automatic out_t deque_predict(in_t req);
    out_t r;
    r.status = ST_OK;
    r.data_out = '0;
    case (req.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_count == QDEPTH) begin
          r.status = ST_FULL;
        end else if (req.cmd == CMD_PUSH_FRONT) begin
          shadow_front = shadow_front - 1'b1;
          shadow_store[shadow_front] = req.data_in;
          shadow_count = shadow_count + 1'b1;
        end else begin
          shadow_store[shadow_back] = req.data_in;
          shadow_back = shadow_back + 1'b1;
          shadow_count = shadow_count + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = shadow_store[shadow_front];
          if (req.cmd == CMD_POP_FRONT) begin
            shadow_front = shadow_front + 1'b1;
            shadow_count = shadow_count - 1'b1;
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = shadow_store[shadow_back - 1'b1];
          if (req.cmd == CMD_POP_BACK) begin
            shadow_back = shadow_back - 1'b1;
            shadow_count = shadow_count - 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        shadow_front = '0;
        shadow_back = '0;
        shadow_count = '0;
      end
      default: begin
      end
    endcase
    r.occupancy = shadow_count;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    logic [DATA_W-1:0] w;
    w = $urandom;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: w = 32'h7fff_ffff;
        1: w = 32'h8000_0000;
        2: w = 32'h0000_0000;
        default: w = 32'hffff_ffff;
      endcase
    end
    return w;
  endfunction

  task automatic add_cmd(logic [2:0] cmd, logic [DATA_W-1:0] data, int unsigned idle_pct,
                         bit drain);
    pending_cmd_t p;
    p.req.cmd = cmd;
    p.req.data_in = data;
    p.gap = 0;
    while ($urandom_range(99) < idle_pct && p.gap < 40) p.gap++;
    p.drain = drain;
    cmd_backlog.push_back(p);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst || cmd_backlog.size() == 0) begin
      start <= 1'b0;
    end else begin
      if (!head_ready) begin
        gap_left = cmd_backlog[0].gap;
        head_ready = 1'b1;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog[0].drain && expected_results.size() != 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        request <= cmd_backlog[0].req;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(deque_predict(request));
        cmd_backlog.pop_front();
        head_ready = 1'b0;
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, result.status);
            mismatches++;
          end
          if (result.data_out !== exp_r.data_out) begin
            $error("data_out: expected %0d, got %0d", exp_r.data_out, result.data_out);
            mismatches++;
          end
          if (result.occupancy !== exp_r.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp_r.occupancy, result.occupancy);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("double_ended_queue_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n;
    int unsigned seg_len;
    int unsigned pct;
    int unsigned r;
    int unsigned idle_tbl[4];
    mode_e mode;
    logic [2:0] c;
    bit drain;

    idle_tbl = '{0, 67, 0, 31};

    // directed corners
    add_cmd(CMD_POP_FRONT, 32'h1234_5678, 0, 1'b0);
    add_cmd(CMD_POP_BACK, 32'h0, 0, 1'b0);
    add_cmd(CMD_PEEK_FRONT, 32'hffff_ffff, 0, 1'b0);
    add_cmd(CMD_PEEK_BACK, 32'h0, 0, 1'b0);
    add_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff, 0, 1'b0);
    add_cmd(CMD_PUSH_BACK, 32'h8000_0000, 0, 1'b0);
    add_cmd(CMD_PUSH_FRONT, 32'hffff_ffff, 0, 1'b0);
    add_cmd(CMD_PUSH_BACK, 32'h0000_0000, 0, 1'b0);
    add_cmd(CMD_PEEK_FRONT, 32'h0, 0, 1'b0);
    add_cmd(CMD_PEEK_BACK, 32'h0, 0, 1'b0);
    add_cmd(CMD_UNUSED, 32'hdead_beef, 0, 1'b0);
    add_cmd(CMD_POP_BACK, 32'h0, 0, 1'b0);
    add_cmd(CMD_POP_FRONT, 32'h0, 0, 1'b0);
    add_cmd(CMD_PUSH_BACK, 32'h5555_5555, 0, 1'b0);
    add_cmd(CMD_PUSH_FRONT, 32'haaaa_aaaa, 0, 1'b0);
    add_cmd(CMD_CLEAR, 32'hffff_ffff, 0, 1'b0);
    add_cmd(CMD_POP_FRONT, 32'h0, 0, 1'b0);
    add_cmd(CMD_PEEK_BACK, 32'h0, 0, 1'b0);
    add_cmd(CMD_PUSH_BACK, 32'h0000_0001, 0, 1'b0);
    add_cmd(CMD_PEEK_BACK, 32'h0, 0, 1'b0);
    add_cmd(CMD_POP_FRONT, 32'h0, 0, 1'b0);

    // random segments; the first fills past full
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == 0) begin
        mode = MODE_FILL;
        seg_len = 72;
      end else begin
        mode = mode_e'($urandom_range(2));
        seg_len = $urandom_range(40, 110);
      end
      drain = (n == 0) || ($urandom_range(2) == 0);
      for (int i = 0; i < seg_len && n < RANDOM_ITEMS; i++) begin
        pct = idle_tbl[(n * 4) / RANDOM_ITEMS];
        r = $urandom_range(99);
        case (mode)
          MODE_FILL: begin
            if (n < 72) c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else if (r < 85) c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else if (r < 92) c = $urandom_range(1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
            else c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
          end
          MODE_DRAIN: begin
            if (r < 85) c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
            else if (r < 92) c = $urandom_range(1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
            else c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
          end
          default: begin
            if (r < 2) c = CMD_CLEAR;
            else if (r < 4) c = CMD_UNUSED;
            else c = $urandom_range(5);
          end
        endcase
        add_cmd(c, pick_word(), pct, drain && i == 0);
        n++;
      end
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("double_ended_queue_tb: clean");
    end else begin
      $display("double_ended_queue_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue.sv
hw/rtl/dq_checker.sv
verif/double_ended_queue_tb.sv
